// ===== rtl/core/rrpb_pkg.sv =====
// Package for the random ring permutation builder: constants, payload structs.
// No dependencies; used by random_ring_permutation_builder.
package rrpb_pkg;
  localparam int MaxCells     = 4096;
  localparam int CellW        = $clog2(MaxCells);
  localparam int CountW       = CellW + 1;
  localparam int WordsPerCell = 8;
  localparam int OffW         = 15;
  localparam int DivStepW     = 7;

  localparam logic [63:0] GoldenSeed = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] XsMult     = 64'h2545F4914F6CDD1D;
  localparam logic [63:0] SeedReset  = 64'd20260806;

  localparam logic [0:0] RegSeed  = 1'b0;
  localparam logic [0:0] RegCount = 1'b1;
  localparam logic       ReqRebuild = 1'b0;

  typedef struct packed {
    logic             req_type;
    logic [CellW-1:0] cell_index;
  } req_t;

  typedef struct packed {
    logic            done_res;
    logic            valid_res;
    logic [OffW-1:0] next_offset;
  } res_t;
endpackage

// ===== rtl/core/rrpb_ram.sv =====
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module rrpb_ram #(
  parameter int Width = 12,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/random_ring_permutation_builder.sv =====
// Random ring builder: Fisher-Yates shuffle (xorshift64*) and successor lookup.
// A lookup reads the successor memory, then loads the output register; lookups
//   stream one per cycle through the successor memory read port while the output is
//   free and no rebuild runs. A rebuild fills, shuffles, then links; the 4-step
//   multiply and the modulo (a load, then nine 7-bit steps) set the shuffle rate.
// The ack waits while the output register is held.
module random_ring_permutation_builder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrpb_pkg::req_t     in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rrpb_pkg::res_t     out_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import rrpb_pkg::*;

  // Reset (rst, synchronous): no ring built, seed=20260806, cell_count=4096.
  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_STEP, S_MUL, S_MOD, S_RDI, S_RDJ, S_SWAP,
    S_LINK_RD0, S_LINK_RD, S_LINK_WR, S_LAST, S_ACK
  } state_t;

  state_t            state;
  logic [63:0]       seed;
  logic [CountW-1:0] cell_count;
  logic [CountW-1:0] n;          // effective cell count of the build
  logic [CountW-1:0] built_count;
  logic              ring_built;
  logic [63:0]       x;          // generator state
  logic [63:0]       prod;       // multiply accumulator
  logic [1:0]        mstep;
  logic [CountW-1:0] rem;        // serial remainder
  logic [63:0]       dvd;        // dividend being shifted out
  logic [3:0]        dstep;
  logic [CellW-1:0]  i;          // shuffle / link index
  logic [CellW-1:0]  j;
  logic [CellW-1:0]  vi;         // order[i]
  logic [CellW-1:0]  first;      // order[0]
  logic [CellW-1:0]  prev;       // order[k-1] during linking

  // order memory port signals
  logic              o_we;
  logic [CellW-1:0]  o_waddr, o_wdata, o_raddr, o_rdata;
  // successor memory port signals
  logic              s_we;
  logic [CellW-1:0]  s_waddr, s_wdata, s_raddr, s_rdata;

  rrpb_ram #(.Width(CellW), .Depth(MaxCells)) u_order (
    .clk, .we(o_we), .waddr(o_waddr), .wdata(o_wdata), .raddr(o_raddr),
    .rdata(o_rdata)
  );
  rrpb_ram #(.Width(CellW), .Depth(MaxCells)) u_succ (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr),
    .rdata(s_rdata)
  );

  // Lookup pipeline: stage 1 waits on the memory read, output reg after it.
  logic              lk_valid, lk_hit;
  logic [CellW-1:0]  lk_cell;    // address held while stage 1 waits
  logic              out_free;
  logic              in_acc;
  logic [63:0]       xs1, xs2, xs3;
  logic [15:0]       pp_a;
  logic [63:0]       pp;
  logic [CountW-1:0] i1;
  logic [CountW+DivStepW-1:0] rsh;
  logic [CountW+DivStepW-1:0] rtmp;
  logic [CountW-1:0] rnext;

  assign out_free = !out_valid || !out_stall;
  // Hold input while rebuilding or when the lookup stage cannot drain.
  assign in_stall = (state != S_IDLE) || (lk_valid && !out_free);
  assign in_acc   = in_valid && !in_stall;

  assign xs1 = x ^ (x >> 12);
  assign xs2 = xs1 ^ (xs1 << 25);
  assign xs3 = xs2 ^ (xs2 >> 27);

  // 64x16 partial product of the multiply, one slice a cycle.
  always_comb begin
    unique case (mstep)
      2'd0:    pp_a = XsMult[15:0];
      2'd1:    pp_a = XsMult[31:16];
      2'd2:    pp_a = XsMult[47:32];
      default: pp_a = XsMult[63:48];
    endcase
    pp = (x * {48'd0, pp_a}) << {mstep, 4'd0};
  end

  assign i1 = {1'b0, i} + 1'b1;

  // Seven restoring-division steps on the remainder; each step is a narrow
  // compare and subtract.
  always_comb begin
    rtmp = '0;
    rsh  = '0;
    rnext = rem;
    for (int b = 0; b < DivStepW; b++) begin
      rsh   = {{DivStepW{1'b0}}, rnext};
      rsh   = (rsh << 1) | (CountW+DivStepW)'(dvd[63-b]);
      rtmp  = rsh - (CountW+DivStepW)'(i1);
      if (!rtmp[CountW+DivStepW-1]) rsh = rtmp;
      rnext = rsh[CountW-1:0];
    end
  end

  always_comb begin
    o_we = 1'b0; o_waddr = i; o_wdata = i; o_raddr = i;
    s_we = 1'b0; s_waddr = prev; s_wdata = o_rdata;
    s_raddr = (lk_valid && !out_free) ? lk_cell : in_data.cell_index;
    unique case (state)
      S_FILL:    o_we = 1'b1;
      S_RDJ:     o_raddr = j;
      S_SWAP: begin
        o_we = 1'b1; o_waddr = i; o_wdata = o_rdata;
      end
      S_ACK: begin
        o_we = 1'b1; o_waddr = j; o_wdata = vi;
      end
      S_LINK_RD0: o_raddr = '0;
      S_LINK_RD:  o_raddr = i;
      S_LINK_WR:  s_we = 1'b1;
      S_LAST: begin
        s_we = 1'b1; s_wdata = first;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      seed        <= SeedReset;
      cell_count  <= CountW'(MaxCells);
      ring_built  <= 1'b0;
      built_count <= '0;
      x           <= '0;
      lk_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegSeed:  seed <= cfg_data;
          default:  cell_count <= cfg_data[CountW-1:0];
        endcase
      end
      // Load the output register from the lookup stage or the rebuild ack.
      if (lk_valid && out_free) begin
        out_valid <= 1'b1;
        out_data  <= '{done_res: 1'b0, valid_res: lk_hit,
                       next_offset: lk_hit ? OffW'(s_rdata) * OffW'(WordsPerCell)
                                           : '0};
      end else if (state == S_LAST && out_free) begin
        out_valid <= 1'b1;
        out_data  <= '{done_res: 1'b1, valid_res: 1'b1, next_offset: '0};
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE && in_acc && in_data.req_type != ReqRebuild) begin
        lk_valid <= 1'b1;
        lk_cell  <= in_data.cell_index;
        lk_hit   <= ring_built && ({1'b0, in_data.cell_index} < built_count);
      end else if (out_free) begin
        lk_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && in_data.req_type == ReqRebuild) begin
            state <= S_FILL;
            i     <= '0;
            if (cell_count == '0) n <= CountW'(1);
            else if (cell_count > CountW'(MaxCells)) n <= CountW'(MaxCells);
            else n <= cell_count;
            x <= (seed != '0) ? seed : GoldenSeed;
          end
        end
        S_FILL: begin
          if (i1 == n) state <= (n == CountW'(1)) ? S_LINK_RD0 : S_STEP;
          else i <= i + 1'b1;
        end
        S_STEP: begin
          x <= xs3; prod <= '0; mstep <= '0; state <= S_MUL;
        end
        S_MUL: begin
          prod  <= prod + pp;
          mstep <= mstep + 1'b1;
          if (mstep == 2'd3) begin
            state <= S_MOD; rem <= '0; dstep <= '0;
          end
        end
        S_MOD: begin
          // Load: the top bit goes straight into the remainder, then nine
          // steps of 7 bits cover the other 63.
          if (dstep == 4'd0) begin
            rem <= {{(CountW-1){1'b0}}, prod[63]};
            dvd <= prod << 1;
          end else begin
            rem <= rnext;
            dvd <= dvd << DivStepW;
          end
          dstep <= dstep + 1'b1;
          if (dstep == 4'd9) state <= S_RDI;
        end
        S_RDI: begin
          j <= rem[CellW-1:0];
          state <= S_RDJ;
        end
        S_RDJ: begin
          vi <= o_rdata;  // order[i]
          state <= S_SWAP;
        end
        S_SWAP: begin
          // order[i] <= order[j] by the port; order[j] <= vi next cycle
          state <= S_ACK;
        end
        S_ACK: begin
          // write order[j]
          if (i == CellW'(1)) begin
            state <= S_LINK_RD0;
          end else begin
            i <= i - 1'b1; state <= S_STEP;
          end
        end
        S_LINK_RD0: begin
          i <= CellW'(1); state <= S_LINK_RD;
        end
        S_LINK_RD: begin
          // order[0] arrives on the first pass
          if (i == CellW'(1)) begin
            first <= o_rdata;
            prev  <= o_rdata;
          end
          state <= (n == CountW'(1)) ? S_LAST : S_LINK_WR;
        end
        S_LINK_WR: begin
          prev <= o_rdata;
          if (i1 == n) begin
            state <= S_LAST;
          end else begin
            i <= i + 1'b1; state <= S_LINK_RD;
          end
        end
        S_LAST: begin
          // Close the ring; hold here until the ack can be sent.
          if (out_free) begin
            state       <= S_IDLE;
            ring_built  <= 1'b1;
            built_count <= n;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_holds_input: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)));
  a_no_lookup_in_build: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !lk_valid);
  a_draw_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDJ) |-> ({1'b0, j} < i1));
endmodule
